FILE: sv/dasd_pkg.sv
// ----------------------------------------------------------------------------
// dasd_pkg
// Shared types, constants and calendar helpers for the date add/subtract block.
// ----------------------------------------------------------------------------
package dasd_pkg;

  localparam int YEAR_W      = 14;
  localparam int MONTH_W     = 4;
  localparam int DAY_W       = 5;
  localparam int STATUS_W    = 2;
  localparam int YMOD_W      = 9;
  localparam int MAX_YEAR    = 9999;
  localparam int CYCLE_DAYS  = 146097;
  localparam int CYCLE_YEARS = 400;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_DATE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUT_RANGE = 2'd2;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CHECK,
    ST_CYCLE,
    ST_WALK,
    ST_FINISH
  } dasd_state_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic check;
    logic cycle_step;
    logic walk_step;
    logic out_load;
  } dasd_cmd_t;

  typedef struct packed {
    logic date_ok;
    logic n_ge_cycle;
    logic n_zero;
  } dasd_stat_t;

  // year mod 400 of a 14-bit year by conditional subtraction
  function automatic logic [YMOD_W-1:0] year_mod400(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] r;
    r = y;
    for (int k = 5; k >= 0; k--) begin
      if (r >= YEAR_W'(CYCLE_YEARS << k)) begin
        r = r - YEAR_W'(CYCLE_YEARS << k);
      end
    end
    return YMOD_W'(r);
  endfunction

  // leap rule from the year's position in the 400-year cycle
  function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
    logic century;
    century = (ymod == YMOD_W'(100)) || (ymod == YMOD_W'(200)) ||
              (ymod == YMOD_W'(300));
    return (ymod[1:0] == 2'b00) && !century;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [MONTH_W-1:0] idx;
    idx = m - MONTH_JAN;
    if ((m < MONTH_JAN) || (m > MONTH_DEC)) begin
      return '0;
    end else if ((m == MONTH_FEB) && leap) begin
      return DAY_W'(29);
    end else begin
      return MONTH_LEN[idx];
    end
  endfunction

endpackage

FILE: sv/date_add_subtract_days_top.sv
// ----------------------------------------------------------------------------
// date_add_subtract_days_top
// Gregorian date plus or minus a day count, with input check and year clamp.
// ----------------------------------------------------------------------------
// An item is accepted in idle; the year is then reduced mod 400 and the date
// is checked. A valid date then passes the 400-year stage, which takes one
// step per whole 146097 days when COUNT_WIDTH exceeds 17, and then the
// datapath's month walk: one step for each month crossed, plus one for a
// remainder inside the last month. When the count has run out, the result
// moves into the output register; an invalid date goes there straight from
// the check. The output register lets the next item start while a result
// still waits to be taken. That item then holds before its own result until
// the register frees.
module date_add_subtract_days_top
  import dasd_pkg::*;
#(
  parameter int COUNT_WIDTH = 16,
  parameter int MIN_YEAR    = 1600
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   mode_i,
  input  logic [YEAR_W-1:0]      year_in_i,
  input  logic [MONTH_W-1:0]     month_in_i,
  input  logic [DAY_W-1:0]       day_in_i,
  input  logic [COUNT_WIDTH-1:0] day_count_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [YEAR_W-1:0]      year_out_o,
  output logic [MONTH_W-1:0]     month_out_o,
  output logic [DAY_W-1:0]       day_out_o,
  output logic [STATUS_W-1:0]    status_o
);

  dasd_cmd_t  cmd;
  dasd_stat_t stat;

  dasd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dasd_dp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .MIN_YEAR    (MIN_YEAR)
  ) u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .mode_i      (mode_i),
    .year_in_i   (year_in_i),
    .month_in_i  (month_in_i),
    .day_in_i    (day_in_i),
    .day_count_i (day_count_i),
    .year_out_o  (year_out_o),
    .month_out_o (month_out_o),
    .day_out_o   (day_out_o),
    .status_o    (status_o)
  );

endmodule

FILE: sv/dasd_ctrl.sv
// ----------------------------------------------------------------------------
// dasd_ctrl
// Sequencer for the date add/subtract block: load, checks, month walk, output.
// ----------------------------------------------------------------------------
module dasd_ctrl
  import dasd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dasd_stat_t stat_i,
  output dasd_cmd_t  cmd_o
);

  dasd_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_PREP;
      end
      ST_PREP: state_d = ST_CHECK;
      ST_CHECK: begin
        state_d = stat_i.date_ok ? ST_CYCLE : ST_FINISH;
      end
      ST_CYCLE: begin
        if (!stat_i.n_ge_cycle) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (stat_i.n_zero) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_PREP:   cmd_o.prep = 1'b1;
      ST_CHECK:  cmd_o.check = 1'b1;
      ST_CYCLE:  cmd_o.cycle_step = stat_i.n_ge_cycle;
      ST_WALK:   cmd_o.walk_step = !stat_i.n_zero;
      ST_FINISH: cmd_o.out_load = out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  // a new result may replace one taken in the same cycle
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/dasd_dp.sv
// ----------------------------------------------------------------------------
// dasd_dp
// Datapath: date registers, 400-year reduction, one month step per cycle,
// range clamp and the output register.
// ----------------------------------------------------------------------------
module dasd_dp
  import dasd_pkg::*;
#(
  parameter int COUNT_WIDTH = 16,
  parameter int MIN_YEAR    = 1600
) (
  input  logic                   clk_i,
  input  dasd_cmd_t              cmd_i,
  output dasd_stat_t             stat_o,
  input  logic                   mode_i,
  input  logic [YEAR_W-1:0]      year_in_i,
  input  logic [MONTH_W-1:0]     month_in_i,
  input  logic [DAY_W-1:0]       day_in_i,
  input  logic [COUNT_WIDTH-1:0] day_count_i,
  output logic [YEAR_W-1:0]      year_out_o,
  output logic [MONTH_W-1:0]     month_out_o,
  output logic [DAY_W-1:0]       day_out_o,
  output logic [STATUS_W-1:0]    status_o
);

  // count register holds at least the 400-year day count
  localparam int NW = (COUNT_WIDTH > 18) ? COUNT_WIDTH : 18;
  // signed year, wide enough for the full drift the count allows
  localparam int YW = (COUNT_WIDTH > 21) ? COUNT_WIDTH - 5 : 16;

  localparam logic signed [YW-1:0] MinYearS   = YW'(MIN_YEAR);
  localparam logic signed [YW-1:0] MaxYearS   = YW'(MAX_YEAR);
  localparam logic signed [YW-1:0] CycYearsS  = YW'(CYCLE_YEARS);
  localparam logic [NW-1:0]        CycDays    = NW'(CYCLE_DAYS);
  localparam logic [YMOD_W-1:0]    YmodLast   = YMOD_W'(CYCLE_YEARS - 1);

  logic                     mode_q;
  logic signed [YW-1:0]     year_q, year_d;
  logic [MONTH_W-1:0]       month_q, month_d;
  logic [DAY_W-1:0]         day_q, day_d;
  logic [NW-1:0]            n_q, n_d;
  logic [YMOD_W-1:0]        ymod_q, ymod_d;
  logic                     bad_q, bad_d;

  logic [YEAR_W-1:0]        year_out_q, year_out_d;
  logic [MONTH_W-1:0]       month_out_q, month_out_d;
  logic [DAY_W-1:0]         day_out_q, day_out_d;
  logic [STATUS_W-1:0]      status_q, status_d;

  logic [DAY_W-1:0]         dim_cur;
  logic [DAY_W:0]           left;
  logic [MONTH_W-1:0]       prev_month;
  logic [YMOD_W-1:0]        prev_ymod;
  logic                     date_ok;

  assign dim_cur = month_days(month_q, is_leap(ymod_q));
  assign left    = {1'b0, dim_cur} - {1'b0, day_q} + (DAY_W+1)'(1);

  assign prev_month = (month_q == MONTH_JAN) ? MONTH_DEC : month_q - MONTH_JAN;
  assign prev_ymod  = (month_q != MONTH_JAN) ? ymod_q :
                      ((ymod_q == '0) ? YmodLast : ymod_q - YMOD_W'(1));

  assign date_ok = (year_q > MinYearS) && (month_q >= MONTH_JAN) &&
                   (month_q <= MONTH_DEC) && (day_q != '0) && (day_q <= dim_cur);

  assign stat_o.date_ok    = date_ok;
  assign stat_o.n_ge_cycle = (n_q >= CycDays);
  assign stat_o.n_zero     = (n_q == '0);

  always_comb begin
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    n_d     = n_q;
    ymod_d  = ymod_q;
    bad_d   = bad_q;
    if (cmd_i.load) begin
      year_d  = YW'(year_in_i);
      month_d = month_in_i;
      day_d   = day_in_i;
      n_d     = NW'(day_count_i);
    end
    if (cmd_i.prep) begin
      ymod_d = year_mod400(year_q[YEAR_W-1:0]);
    end
    if (cmd_i.check) begin
      bad_d = !date_ok;
    end
    if (cmd_i.cycle_step) begin
      n_d    = n_q - CycDays;
      year_d = mode_q ? year_q - CycYearsS : year_q + CycYearsS;
    end
    if (cmd_i.walk_step) begin
      if (!mode_q) begin
        if (n_q >= NW'(left)) begin
          n_d   = n_q - NW'(left);
          day_d = DAY_W'(1);
          if (month_q == MONTH_DEC) begin
            month_d = MONTH_JAN;
            year_d  = year_q + YW'(1);
            ymod_d  = (ymod_q == YmodLast) ? '0 : ymod_q + YMOD_W'(1);
          end else begin
            month_d = month_q + MONTH_W'(1);
          end
        end else begin
          // remainder fits in this month
          day_d = day_q + n_q[DAY_W-1:0];
          n_d   = '0;
        end
      end else begin
        if (n_q >= NW'(day_q)) begin
          n_d     = n_q - NW'(day_q);
          month_d = prev_month;
          ymod_d  = prev_ymod;
          if (month_q == MONTH_JAN) year_d = year_q - YW'(1);
          day_d = month_days(prev_month, is_leap(prev_ymod));
        end else begin
          day_d = day_q - n_q[DAY_W-1:0];
          n_d   = '0;
        end
      end
    end
  end

  always_comb begin
    if (bad_q) begin
      year_out_d  = '0;
      month_out_d = '0;
      day_out_d   = '0;
      status_d    = STATUS_BAD_DATE;
    end else if (year_q <= MinYearS) begin
      year_out_d  = YEAR_W'(MIN_YEAR + 1);
      month_out_d = MONTH_JAN;
      day_out_d   = DAY_W'(1);
      status_d    = STATUS_OUT_RANGE;
    end else if (year_q > MaxYearS) begin
      year_out_d  = YEAR_W'(MAX_YEAR);
      month_out_d = MONTH_DEC;
      day_out_d   = DAY_W'(31);
      status_d    = STATUS_OUT_RANGE;
    end else begin
      year_out_d  = year_q[YEAR_W-1:0];
      month_out_d = month_q;
      day_out_d   = day_q;
      status_d    = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) mode_q <= mode_i;
    year_q  <= year_d;
    month_q <= month_d;
    day_q   <= day_d;
    n_q     <= n_d;
    ymod_q  <= ymod_d;
    bad_q   <= bad_d;
    if (cmd_i.out_load) begin
      year_out_q  <= year_out_d;
      month_out_q <= month_out_d;
      day_out_q   <= day_out_d;
      status_q    <= status_d;
    end
  end

  assign year_out_o  = year_out_q;
  assign month_out_o = month_out_q;
  assign day_out_o   = day_out_q;
  assign status_o    = status_q;

endmodule
